// ===== sv/plane_basis_from_normal_macros.svh =====
// ----------------------------------------------------------------------------
// plane_basis_from_normal assertion macros
// shared concurrent assertion forms, sampled on clk, off during rst
// ----------------------------------------------------------------------------
`ifndef PLANE_BASIS_FROM_NORMAL_MACROS_SVH
`define PLANE_BASIS_FROM_NORMAL_MACROS_SVH

// same-cycle implication
`define PBN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PBN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pbn_pkg.sv =====
// ----------------------------------------------------------------------------
// pbn_pkg
// shared types and constants of the plane basis pipeline
// ----------------------------------------------------------------------------
package pbn_pkg;

  localparam int DATA_W    = 32;
  localparam int WIDE_W    = 64;
  localparam int TOL_W     = 17;
  localparam int TOL_SHIFT = 14;

  // unit vector pipeline stages: magnitude, lead one, shift, square, sum,
  // 32 root steps, numerator, 31 quotient steps, sign
  localparam int UNIT_LAT  = 70;
  localparam int SEED_LAT  = 1;
  localparam int CROSS_LAT = 2;

  localparam logic [TOL_W-1:0] TOL_RESET = 17'd66;
  localparam logic [WIDE_W-1:0] ONE_Q30  = 64'd1 << 30;

  typedef logic signed [DATA_W-1:0] q30_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

endpackage

// ===== sv/plane_basis_from_normal.sv =====
// throughput: one vector per cycle unless the output stalls, set by the
//   fully pipelined root and quotient steps of the three
//   normalizers (one bit per stage)
// a stalled output freezes the whole pipeline; nothing is dropped
// reset: synchronous rst clears all valid bits and loads tolerance with 66
// ----------------------------------------------------------------------------
// plane_basis_from_normal
// orthonormal frame (unit normal, two in-plane unit vectors) from a normal
// ----------------------------------------------------------------------------
`include "plane_basis_from_normal_macros.svh"

module plane_basis_from_normal (
  input  logic         clk,
  input  logic         rst,
  // tolerance register write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [16:0]  cfg_data,
  // input vector
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // norm_x, norm_y, norm_z
  // result frame
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,   // unit_x/y/z, first_x/y/z, second_x/y/z
  output logic [0:0]   m_tuser    // zero_error
);

  localparam int U_SIDE = 3 * pbn_pkg::DATA_W + 1;
  localparam int F_SIDE = 6 * pbn_pkg::DATA_W + 1;

  logic [pbn_pkg::TOL_W-1:0] tol;
  logic                      en;
  pbn_pkg::wide_t            nv [3];
  logic                      in_zero;

  logic                      u1_valid;
  pbn_pkg::q30_t             u1_res [3];
  logic [0:0]                u1_side;

  logic                      sd_valid;
  pbn_pkg::wide_t            sd_w [3];
  pbn_pkg::q30_t             sd_u [3];
  logic                      sd_zero;

  logic                      u2_valid;
  pbn_pkg::q30_t             u2_res [3];
  logic [U_SIDE-1:0]         u2_side;
  pbn_pkg::q30_t             u2_u [3];

  logic                      cr_valid;
  pbn_pkg::wide_t            cr_c [3];
  pbn_pkg::q30_t             cr_u [3];
  pbn_pkg::q30_t             cr_f [3];
  logic                      cr_zero;

  logic                      u3_valid;
  pbn_pkg::q30_t             u3_res [3];
  logic [F_SIDE-1:0]         u3_side;
  logic                      out_zero;

  // tolerance register; always ready; to be configured only while idle, which the block itself does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= pbn_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  // the whole pipeline moves together unless a finished result waits
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // sign-extend the Q16.16 components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = {{32{s_tdata[32*i+31]}}, s_tdata[32*i +: 32]};
    end
    in_zero = (s_tdata == '0);
  end

  // unit normal
  pbn_unit #(.SIDE_W(1)) u_norm (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid && s_tready), .vec(nv), .in_side(in_zero),
    .out_valid(u1_valid), .res(u1_res), .out_side(u1_side)
  );

  // unnormalized first in-plane vector
  pbn_seed u_seed (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(u1_valid), .u(u1_res), .in_zero(u1_side[0]), .tol(tol),
    .out_valid(sd_valid), .w(sd_w), .u_out(sd_u), .out_zero(sd_zero)
  );

  // first in-plane unit vector, unit normal rides along
  pbn_unit #(.SIDE_W(U_SIDE)) u_first (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sd_valid), .vec(sd_w),
    .in_side({sd_zero, sd_u[2], sd_u[1], sd_u[0]}),
    .out_valid(u2_valid), .res(u2_res), .out_side(u2_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) u2_u[i] = u2_side[32*i +: 32];
  end

  // u x f
  pbn_cross u_cross (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(u2_valid), .u(u2_u), .f(u2_res), .in_zero(u2_side[U_SIDE-1]),
    .out_valid(cr_valid), .c(cr_c), .u_out(cr_u), .f_out(cr_f), .out_zero(cr_zero)
  );

  // second in-plane unit vector; a zero cross product comes out as zero
  pbn_unit #(.SIDE_W(F_SIDE)) u_second (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cr_valid), .vec(cr_c),
    .in_side({cr_zero, cr_f[2], cr_f[1], cr_f[0], cr_u[2], cr_u[1], cr_u[0]}),
    .out_valid(u3_valid), .res(u3_res), .out_side(u3_side)
  );

  // zero input forces the whole frame to zero
  assign out_zero = u3_side[F_SIDE-1];
  assign m_tvalid = u3_valid;
  assign m_tuser = out_zero;
  assign m_tdata = out_zero ? '0
                 : {u3_res[2], u3_res[1], u3_res[0], u3_side[F_SIDE-2:0]};

  // zero flag implies an all-zero frame
  `PBN_ASSERT_IMP(a_zero_frame, m_tvalid && m_tuser[0], m_tdata == '0, "zero flag with data")
  // a nonzero input always yields a nonzero unit normal
  `PBN_ASSERT_IMP(a_unit_nonzero, m_tvalid && !m_tuser[0], m_tdata[95:0] != '0,
                  "unit normal is zero")
  // the first in-plane vector is never zero for a nonzero input
  `PBN_ASSERT_IMP(a_first_nonzero, m_tvalid && !m_tuser[0], m_tdata[191:96] != '0,
                  "first vector is zero")
  // a held result keeps the whole pipeline frozen
  `PBN_ASSERT_NXT(a_hold, m_tvalid && !m_tready, $stable(u2_valid) && $stable(u1_valid),
                  "pipeline moved during stall")

endmodule

// ===== sv/pbn_unit.sv =====
// ----------------------------------------------------------------------------
// pbn_unit
// pipelined normalizer: scales a 3-vector to Q2.30 unit length
// ----------------------------------------------------------------------------
module pbn_unit #(
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  pbn_pkg::wide_t      vec [3],
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output pbn_pkg::q30_t       res [3],
  output logic [SIDE_W-1:0]   out_side
);

  localparam int LAT = pbn_pkg::UNIT_LAT;
  localparam int SQ_N = 32;
  localparam int DV_N = 31;

  // front stages
  logic [63:0] mag1 [3];
  logic [63:0] mag2 [3];
  logic [5:0]  pos2;
  logic [30:0] nm3 [3];
  logic [61:0] sq4 [3];
  logic [30:0] nm4 [3];
  logic [63:0] sum5;
  logic [30:0] nm5 [3];

  // root stages
  logic [63:0] sq_rem  [SQ_N];
  logic [31:0] sq_root [SQ_N];
  logic [30:0] sq_nm   [SQ_N][3];
  logic [63:0] a_rem   [SQ_N+1];
  logic [31:0] a_root  [SQ_N+1];
  logic [30:0] a_nm    [SQ_N+1][3];
  logic [63:0] n_rem   [SQ_N];
  logic [31:0] n_root  [SQ_N];

  // quotient stages
  logic [61:0] num38 [3];
  logic [31:0] len38;
  logic [32:0] dv_rem [DV_N][3];
  logic [30:0] dv_low [DV_N][3];
  logic [30:0] dv_q   [DV_N][3];
  logic [31:0] dv_len [DV_N];
  logic [32:0] b_rem  [DV_N+1][3];
  logic [30:0] b_low  [DV_N+1][3];
  logic [30:0] b_q    [DV_N+1][3];
  logic [31:0] b_len  [DV_N+1];
  logic [32:0] m_rem  [DV_N][3];
  logic [30:0] m_q    [DV_N][3];

  // side line
  logic              vld_d  [LAT];
  logic [SIDE_W-1:0] side_d [LAT];
  logic [2:0]        neg_d  [LAT];
  logic              zero_d [LAT];

  logic [63:0] any1;
  logic [5:0]  pos_c;
  logic [30:0] nm_c [3];

  always_comb begin
    any1 = mag1[0] | mag1[1] | mag1[2];
    pos_c = '0;
    for (int b = 0; b < 64; b++) begin
      if (any1[b]) pos_c = 6'(b);
    end
    for (int i = 0; i < 3; i++) begin
      if (pos2 > 6'd30) nm_c[i] = 31'(mag2[i] >> (pos2 - 6'd30));
      else nm_c[i] = 31'(mag2[i] << (6'd30 - pos2));
    end
  end

  // restoring square root, one result bit per stage
  always_comb begin
    logic [65:0] cand;
    int b;
    a_rem[0] = sum5;
    a_root[0] = '0;
    a_nm[0] = nm5;
    for (int k = 0; k < SQ_N; k++) begin
      a_rem[k+1] = sq_rem[k];
      a_root[k+1] = sq_root[k];
      a_nm[k+1] = sq_nm[k];
    end
    for (int k = 0; k < SQ_N; k++) begin
      b = SQ_N - 1 - k;
      cand = ({34'b0, a_root[k]} << (b + 1)) + (66'd1 << (2 * b));
      if ({2'b0, a_rem[k]} >= cand) begin
        n_rem[k] = a_rem[k] - cand[63:0];
        n_root[k] = a_root[k] | (32'd1 << b);
      end else begin
        n_rem[k] = a_rem[k];
        n_root[k] = a_root[k];
      end
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [32:0] t;
    int b;
    b_len[0] = len38;
    for (int i = 0; i < 3; i++) begin
      b_rem[0][i] = {2'b0, num38[i][61:31]};
      b_low[0][i] = num38[i][30:0];
      b_q[0][i] = '0;
    end
    for (int k = 0; k < DV_N; k++) begin
      b_len[k+1] = dv_len[k];
      b_rem[k+1] = dv_rem[k];
      b_low[k+1] = dv_low[k];
      b_q[k+1] = dv_q[k];
    end
    for (int k = 0; k < DV_N; k++) begin
      b = DV_N - 1 - k;
      for (int i = 0; i < 3; i++) begin
        t = {b_rem[k][i][31:0], b_low[k][i][b]};
        if (t >= {1'b0, b_len[k]}) begin
          m_rem[k][i] = t - {1'b0, b_len[k]};
          m_q[k][i] = b_q[k][i] | (31'd1 << b);
        end else begin
          m_rem[k][i] = t;
          m_q[k][i] = b_q[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= vec[i][63] ? (~vec[i] + 64'd1) : vec[i];
        mag2[i] <= mag1[i];
        nm3[i] <= nm_c[i];
        sq4[i] <= nm3[i] * nm3[i];
        nm4[i] <= nm3[i];
        nm5[i] <= nm4[i];
        num38[i] <= {1'b0, a_nm[SQ_N][i], 30'b0} + {31'b0, a_root[SQ_N][31:1]};
      end
      pos2 <= pos_c;
      sum5 <= {2'b0, sq4[0]} + {2'b0, sq4[1]} + {2'b0, sq4[2]};
      for (int k = 0; k < SQ_N; k++) begin
        sq_rem[k] <= n_rem[k];
        sq_root[k] <= n_root[k];
        sq_nm[k] <= a_nm[k];
      end
      len38 <= a_root[SQ_N];
      for (int k = 0; k < DV_N; k++) begin
        dv_len[k] <= b_len[k];
        dv_rem[k] <= m_rem[k];
        dv_low[k] <= b_low[k];
        dv_q[k] <= m_q[k];
      end
      for (int i = 0; i < 3; i++) begin
        if (zero_d[LAT-2]) res[i] <= '0;
        else if (neg_d[LAT-2][i]) res[i] <= -$signed({1'b0, b_q[DV_N][i]});
        else res[i] <= $signed({1'b0, b_q[DV_N][i]});
      end
      side_d[0] <= in_side;
      neg_d[0] <= {vec[2][63], vec[1][63], vec[0][63]};
      zero_d[0] <= (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
      for (int j = 1; j < LAT; j++) begin
        side_d[j] <= side_d[j-1];
        neg_d[j] <= neg_d[j-1];
        zero_d[j] <= zero_d[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LAT; j++) vld_d[j] <= 1'b0;
    end else if (en) begin
      vld_d[0] <= in_valid;
      for (int j = 1; j < LAT; j++) vld_d[j] <= vld_d[j-1];
    end
  end

  assign out_valid = vld_d[LAT-1];
  assign out_side = side_d[LAT-1];

endmodule

// ===== sv/pbn_seed.sv =====
// ----------------------------------------------------------------------------
// pbn_seed
// builds the unnormalized first in-plane vector from the unit normal
// ----------------------------------------------------------------------------
module pbn_seed (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  pbn_pkg::q30_t                       u [3],
  input  logic                                in_zero,
  input  logic [pbn_pkg::TOL_W-1:0]           tol,
  output logic                                out_valid,
  output pbn_pkg::wide_t                      w [3],
  output pbn_pkg::q30_t                       u_out [3],
  output logic                                out_zero
);

  logic [30:0]        lim;
  logic [31:0]        abs_t [3];
  logic [2:0]         unset;
  logic               found;
  logic [1:0]         first;
  logic signed [33:0] others;
  logic signed [33:0] solved;
  pbn_pkg::wide_t     w_c [3];

  always_comb begin
    lim = {tol, 14'b0};
    found = 1'b0;
    first = '0;
    others = '0;
    for (int i = 0; i < 3; i++) begin
      abs_t[i] = u[i][31] ? 32'(-u[i]) : 32'(u[i]);
      unset[i] = abs_t[i][30:0] > lim;
    end
    for (int i = 0; i < 3; i++) begin
      if (unset[i]) begin
        if (!found) begin
          found = 1'b1;
          first = 2'(i);
        end else begin
          others = others + {{2{u[i][31]}}, u[i]};
        end
      end
    end
    solved = u[first][31] ? others : -others;
    for (int i = 0; i < 3; i++) begin
      if (!found) w_c[i] = pbn_pkg::ONE_Q30;
      else if (2'(i) == first) w_c[i] = {{30{solved[33]}}, solved};
      else w_c[i] = {33'b0, abs_t[first][30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w <= w_c;
      u_out <= u;
      out_zero <= in_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

endmodule

// ===== sv/pbn_cross.sv =====
// ----------------------------------------------------------------------------
// pbn_cross
// two-stage cross product u x f: products, then differences
// ----------------------------------------------------------------------------
module pbn_cross (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  pbn_pkg::q30_t  u [3],
  input  pbn_pkg::q30_t  f [3],
  input  logic           in_zero,
  output logic           out_valid,
  output pbn_pkg::wide_t c [3],
  output pbn_pkg::q30_t  u_out [3],
  output pbn_pkg::q30_t  f_out [3],
  output logic           out_zero
);

  pbn_pkg::wide_t prod [6];
  pbn_pkg::q30_t  u1 [3];
  pbn_pkg::q30_t  f1 [3];
  logic           zero1;
  logic           vld1;

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= u[1] * f[2];
      prod[1] <= u[2] * f[1];
      prod[2] <= u[2] * f[0];
      prod[3] <= u[0] * f[2];
      prod[4] <= u[0] * f[1];
      prod[5] <= u[1] * f[0];
      u1 <= u;
      f1 <= f;
      zero1 <= in_zero;
      c[0] <= prod[0] - prod[1];
      c[1] <= prod[2] - prod[3];
      c[2] <= prod[4] - prod[5];
      u_out <= u1;
      f_out <= f1;
      out_zero <= zero1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
      out_valid <= vld1;
    end
  end

endmodule
